// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication or plain property, checked on every rising edge out of reset
`define ASSERT_PROP(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// expression that must never be true
`define ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, clk, rstn, prop)
`define ASSERT_NEVER(name, clk, rstn, expr)
`endif
`endif

// ===== hw/rtl/org_pkg.sv =====
// types, constants and codes of the order risk gate
package org_pkg;

  // rate window ring
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int CMP_W      = CNT_W + 8;
  localparam logic [63:0] WINDOW_NS = 64'd1000000000;

  // stream and register port widths
  localparam int IN_TDATA_W  = 328;
  localparam int OUT_TDATA_W = 104;
  localparam int APB_AW      = 6;
  localparam int APB_DW      = 64;

  // register indexes
  typedef enum logic [2:0] {
    REG_RATE_LIMIT = 3'd0,
    REG_SIZE_LIMIT = 3'd1,
    REG_PRICE_LIMIT = 3'd2,
    REG_VALUE_LIMIT = 3'd3,
    REG_POS_LIMIT = 3'd4,
    REG_POS_VALUE_LIMIT = 3'd5
  } org_reg_e;

  typedef enum logic [3:0] {
    RSN_OK = 4'd0,
    RSN_RATE = 4'd1,
    RSN_SIZE = 4'd2,
    RSN_PRICE = 4'd3,
    RSN_VALUE = 4'd4,
    RSN_POSITION = 4'd5,
    RSN_POS_VALUE = 4'd6,
    RSN_LOCATES = 4'd7,
    RSN_UNSET = 4'd8
  } org_reason_e;

  typedef enum logic [1:0] {
    SIDE_BUY = 2'd0,
    SIDE_SELL = 2'd1,
    SIDE_SHORT = 2'd2,
    SIDE_SHORT_EXEMPT = 2'd3
  } org_side_e;

  typedef enum logic [0:0] {
    OP_VALIDATE = 1'b0,
    OP_LOCATE_UPDATE = 1'b1
  } org_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EXPIRE,
    ST_CHK_LIM,
    ST_CHK_VAL,
    ST_CHK_POS,
    ST_MUL_HI,
    ST_CHK_PVAL,
    ST_RESULT
  } org_state_e;

  typedef struct packed {
    logic signed [7:0] rate_limit;
    logic [31:0]       size_limit;
    logic [31:0]       price_limit;
    logic [62:0]       value_limit;
    logic [46:0]       position_limit;
    logic [62:0]       position_value_limit;
  } org_cfg_t;

  typedef struct packed {
    org_op_e            op;
    logic [62:0]        order_time_ns;
    logic [31:0]        order_size;
    logic [31:0]        order_price;
    org_side_e          order_side;
    logic signed [47:0] held_quantity;
    logic signed [47:0] away_quantity;
    logic [46:0]        open_short_qty;
    logic signed [47:0] locate_target;
    logic               grow_only;
  } org_item_t;

  typedef struct packed {
    logic               accepted;
    org_reason_e        reject_reason;
    org_side_e          final_side;
    logic [47:0]        locates_taken;
    logic signed [47:0] locates_left;
  } org_result_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] ring_count;
  } org_back_status_t;

endpackage

// ===== hw/rtl/org_ram.sv =====
// generic single write port ram with registered read
module org_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/org_front.sv =====
// front end: takes requests, decodes them and queues them for the back end
module org_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [org_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tuser,
  output logic                             q_valid_o,
  output org_pkg::org_item_t               q_item_o,
  input  logic                             q_pop_i
);
  org_pkg::org_item_t item;
  org_pkg::org_item_t mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // unpack the request fields
  always_comb begin
    item.op             = org_pkg::org_op_e'(s_axis_tuser);
    item.order_time_ns  = s_axis_tdata[62:0];
    item.order_size     = s_axis_tdata[94:63];
    item.order_price    = s_axis_tdata[126:95];
    item.order_side     = org_pkg::org_side_e'(s_axis_tdata[128:127]);
    item.held_quantity  = s_axis_tdata[176:129];
    item.away_quantity  = s_axis_tdata[224:177];
    item.open_short_qty = s_axis_tdata[271:225];
    item.locate_target  = s_axis_tdata[319:272];
    item.grow_only      = s_axis_tdata[320];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_item_o      = mem_q[rptr_q];

  // queue pointers and fill
  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item;
    end
  end
endmodule

// ===== hw/rtl/org_back.sv =====
// back end: rate window, limit checks, locate bookkeeping and result register
module org_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  org_pkg::org_cfg_t         cfg_i,
  input  logic                      q_valid_i,
  input  org_pkg::org_item_t        q_item_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  output org_pkg::org_result_t      out_o,
  input  logic                      out_ready_i,
  output org_pkg::org_back_status_t status_o
);
  localparam int AW = org_pkg::RING_AW;
  localparam int CW = org_pkg::CNT_W;

  org_pkg::org_state_e state_q, state_d;
  org_pkg::org_item_t  item_q, item_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [47:0]         bal_q, bal_d, allow_q, allow_d;
  logic                known_q, known_d;
  logic [63:0]         prod_q, prod_d;
  logic [49:0]         post_q, post_d, apos_q, apos_d;
  logic [51:0]         post2_q, post2_d, need_q, need_d;
  logic [55:0]         pplo_q, pplo_d;
  logic [54:0]         pphi_q, pphi_d;
  logic                racc_q, racc_d;
  org_pkg::org_reason_e rrsn_q, rrsn_d;
  org_pkg::org_side_e  rside_q, rside_d;
  logic [47:0]         rtaken_q, rtaken_d;
  logic                ovalid_q, ovalid_d;
  org_pkg::org_result_t odata_q, odata_d;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [62:0]         rdata;
  logic                rate_on;
  logic [48:0]         diff;
  logic [49:0]         bal_sum;
  logic [49:0]         held50, rem50, size50;
  logic [79:0]         pval;
  logic [51:0]         avail;
  logic [CW:0]         wsum;
  logic [AW-1:0]       head_inc;

  // timestamp ring of accepted orders
  org_ram #(.WIDTH(63), .DEPTH(org_pkg::RING_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_q.order_time_ns),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  assign rate_on = !cfg_i.rate_limit[7];
  assign head_inc = (head_q == AW'(org_pkg::RING_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // tail slot of the ring
  always_comb begin
    wsum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
    if (wsum >= (CW + 1)'(org_pkg::RING_DEPTH)) begin
      wsum = wsum - (CW + 1)'(org_pkg::RING_DEPTH);
    end
    waddr = wsum[AW-1:0];
  end

  // shared arithmetic
  always_comb begin
    diff    = {item_q.locate_target[47], item_q.locate_target} - {allow_q[47], allow_q};
    bal_sum = {{2{bal_q[47]}}, bal_q} + {diff[48], diff};
    held50  = {{2{item_q.held_quantity[47]}}, item_q.held_quantity};
    rem50   = {{2{item_q.away_quantity[47]}}, item_q.away_quantity};
    size50  = {18'd0, item_q.order_size};
    pval    = {1'b0, pphi_q, 24'd0} + {24'd0, pplo_q};
    avail   = bal_q[47] ? 52'd0 : {4'd0, bal_q};
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    head_d   = head_q;
    count_d  = count_q;
    bal_d    = bal_q;
    allow_d  = allow_q;
    known_d  = known_q;
    prod_d   = prod_q;
    post_d   = post_q;
    apos_d   = apos_q;
    post2_d  = post2_q;
    need_d   = need_q;
    pplo_d   = pplo_q;
    pphi_d   = pphi_q;
    racc_d   = racc_q;
    rrsn_d   = rrsn_q;
    rside_d  = rside_q;
    rtaken_d = rtaken_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d  = odata_q;
    q_pop_o  = 1'b0;
    we       = 1'b0;
    case (state_q)
      org_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          state_d = org_pkg::ST_LOAD;
        end
      end
      org_pkg::ST_LOAD: begin
        racc_d   = 1'b0;
        rrsn_d   = org_pkg::RSN_OK;
        rside_d  = item_q.order_side;
        rtaken_d = '0;
        if (item_q.op == org_pkg::OP_LOCATE_UPDATE) begin
          rside_d = org_pkg::SIDE_BUY;
          state_d = org_pkg::ST_RESULT;
          if (diff != '0 && !(item_q.grow_only && (diff[48] || diff == '0))) begin
            racc_d  = 1'b1;
            allow_d = item_q.locate_target;
            known_d = 1'b1;
            if (bal_sum[49:47] == 3'b000 || bal_sum[49:47] == 3'b111) begin
              bal_d = bal_sum[47:0];
            end else begin
              bal_d = bal_sum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end
          end
        end else if (rate_on) begin
          state_d = org_pkg::ST_EXPIRE;
        end else begin
          state_d = org_pkg::ST_CHK_LIM;
        end
      end
      // drop stale times from the oldest end, one per cycle
      org_pkg::ST_EXPIRE: begin
        if (count_q != '0 &&
            ({1'b0, rdata} + org_pkg::WINDOW_NS < {1'b0, item_q.order_time_ns})) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
        end else begin
          state_d = org_pkg::ST_CHK_LIM;
        end
      end
      org_pkg::ST_CHK_LIM: begin
        prod_d  = 64'(item_q.order_size) * 64'(item_q.order_price);
        post_d  = (item_q.order_side == org_pkg::SIDE_BUY) ? held50 + rem50 + size50
                                                           : held50 + rem50 - size50;
        state_d = org_pkg::ST_CHK_VAL;
        if (rate_on && ((org_pkg::CMP_W'(count_q) + 1'b1 >
                         org_pkg::CMP_W'(cfg_i.rate_limit[6:0])) ||
                        count_q == CW'(org_pkg::RING_DEPTH))) begin
          rrsn_d  = org_pkg::RSN_RATE;
          state_d = org_pkg::ST_RESULT;
        end else if (item_q.order_size > cfg_i.size_limit) begin
          rrsn_d  = org_pkg::RSN_SIZE;
          state_d = org_pkg::ST_RESULT;
        end else if (item_q.order_price > cfg_i.price_limit) begin
          rrsn_d  = org_pkg::RSN_PRICE;
          state_d = org_pkg::ST_RESULT;
        end
      end
      org_pkg::ST_CHK_VAL: begin
        apos_d  = post_q[49] ? -post_q : post_q;
        post2_d = {{2{post_q[49]}}, post_q} - {5'd0, item_q.open_short_qty};
        state_d = org_pkg::ST_CHK_POS;
        if (prod_q > {1'b0, cfg_i.value_limit}) begin
          rrsn_d  = org_pkg::RSN_VALUE;
          state_d = org_pkg::ST_RESULT;
        end
      end
      org_pkg::ST_CHK_POS: begin
        pplo_d  = 56'(apos_q[23:0]) * 56'(item_q.order_price);
        state_d = org_pkg::ST_MUL_HI;
        if (apos_q > {3'd0, cfg_i.position_limit}) begin
          rrsn_d  = org_pkg::RSN_POSITION;
          state_d = org_pkg::ST_RESULT;
        end
      end
      org_pkg::ST_MUL_HI: begin
        pphi_d  = 55'(apos_q[46:24]) * 55'(item_q.order_price);
        need_d  = post2_q[51] ? -post2_q : '0;
        state_d = org_pkg::ST_CHK_PVAL;
      end
      // position value, side correction and locate draw
      org_pkg::ST_CHK_PVAL: begin
        state_d = org_pkg::ST_RESULT;
        if (pval > {17'd0, cfg_i.position_value_limit}) begin
          rrsn_d = org_pkg::RSN_POS_VALUE;
        end else if (item_q.order_side == org_pkg::SIDE_BUY) begin
          racc_d = 1'b1;
          we     = rate_on;
          count_d = rate_on ? count_q + 1'b1 : count_q;
        end else begin
          if (post2_q[51]) begin
            rside_d = org_pkg::SIDE_SHORT;
          end else begin
            rside_d = org_pkg::SIDE_SELL;
          end
          if (!known_q) begin
            rrsn_d = org_pkg::RSN_UNSET;
          end else if (need_q > avail) begin
            rrsn_d = org_pkg::RSN_LOCATES;
          end else begin
            racc_d   = 1'b1;
            rtaken_d = need_q[47:0];
            bal_d    = bal_q - need_q[47:0];
            we       = rate_on;
            count_d  = rate_on ? count_q + 1'b1 : count_q;
          end
        end
      end
      org_pkg::ST_RESULT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d              = 1'b1;
          odata_d.accepted      = racc_q;
          odata_d.reject_reason = rrsn_q;
          odata_d.final_side    = rside_q;
          odata_d.locates_taken = rtaken_q;
          odata_d.locates_left  = bal_q;
          state_d               = org_pkg::ST_IDLE;
        end
      end
      default: state_d = org_pkg::ST_IDLE;
    endcase
  end

  // control and locate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= org_pkg::ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      bal_q    <= '0;
      allow_q  <= '0;
      known_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      bal_q    <= bal_d;
      allow_q  <= allow_d;
      known_q  <= known_d;
      ovalid_q <= ovalid_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    prod_q   <= prod_d;
    post_q   <= post_d;
    apos_q   <= apos_d;
    post2_q  <= post2_d;
    need_q   <= need_d;
    pplo_q   <= pplo_d;
    pphi_q   <= pphi_d;
    racc_q   <= racc_d;
    rrsn_q   <= rrsn_d;
    rside_q  <= rside_d;
    rtaken_q <= rtaken_d;
    odata_q  <= odata_d;
  end

  assign out_valid_o         = ovalid_q;
  assign out_o               = odata_q;
  assign status_o.busy       = (state_q != org_pkg::ST_IDLE);
  assign status_o.ring_count = count_q;
endmodule

// ===== hw/rtl/order_risk_gate.sv =====
// top level of the order risk gate: register port, front end and back end
//
// channel   dir  handshake        payload
// s_axis    in   tvalid/tready    request: order or locate update
// m_axis    out  tvalid/tready    one result per request
// apb       in   psel/penable     limit registers, 64 bit data, 8 byte stride
//
// an order goes through load, expire (with the rate check on), the limit, value,
// position, high multiply and position value checks, then result; the sequencer
// walks the timestamp ring one entry per cycle and splits the position value
// product in two halves. an order rejected early finishes sooner; a locate update goes from load to result.
// reset clears the ring count, locate balance and allowance; ring memory is
// not cleared. a two entry queue keeps taking requests, until it is full, while
// the back end works or a result waits in the output register.
`include "assert_macros.svh"
module order_risk_gate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // op_time[62:0] size[94:63] price[126:95] side[128:127] held[176:129]
  // remote[224:177] short_open[271:225] new_locate[319:272] only_if_inc[320]
  input  logic [org_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // op[0]
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // accepted[0] reason[4:1] final_side[6:5] taken[54:7] left[102:55]
  output logic [org_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [org_pkg::APB_AW-1:0]      paddr,
  input  logic [org_pkg::APB_DW-1:0]      pwdata,
  output logic [org_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  org_pkg::org_cfg_t         cfg_q;
  org_pkg::org_item_t        q_item;
  org_pkg::org_result_t      res;
  org_pkg::org_back_status_t status;
  logic                      q_valid, q_pop, wr_en;
  org_pkg::org_reg_e         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = org_pkg::org_reg_e'(paddr[5:3]);

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_limit           <= -8'sd1;
      cfg_q.size_limit           <= '0;
      cfg_q.price_limit          <= '0;
      cfg_q.value_limit          <= '0;
      cfg_q.position_limit       <= '0;
      cfg_q.position_value_limit <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        org_pkg::REG_RATE_LIMIT:      cfg_q.rate_limit           <= pwdata[7:0];
        org_pkg::REG_SIZE_LIMIT:      cfg_q.size_limit           <= pwdata[31:0];
        org_pkg::REG_PRICE_LIMIT:     cfg_q.price_limit          <= pwdata[31:0];
        org_pkg::REG_VALUE_LIMIT:     cfg_q.value_limit          <= pwdata[62:0];
        org_pkg::REG_POS_LIMIT:       cfg_q.position_limit       <= pwdata[46:0];
        org_pkg::REG_POS_VALUE_LIMIT: cfg_q.position_value_limit <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      org_pkg::REG_RATE_LIMIT:      prdata = {{56{cfg_q.rate_limit[7]}}, cfg_q.rate_limit};
      org_pkg::REG_SIZE_LIMIT:      prdata = {32'd0, cfg_q.size_limit};
      org_pkg::REG_PRICE_LIMIT:     prdata = {32'd0, cfg_q.price_limit};
      org_pkg::REG_VALUE_LIMIT:     prdata = {1'b0, cfg_q.value_limit};
      org_pkg::REG_POS_LIMIT:       prdata = {17'd0, cfg_q.position_limit};
      org_pkg::REG_POS_VALUE_LIMIT: prdata = {1'b0, cfg_q.position_value_limit};
      default:                      prdata = '0;
    endcase
  end

  org_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  org_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_o       (res),
    .out_ready_i (m_axis_tready),
    .status_o    (status)
  );

  // result packing
  assign m_axis_tdata = {1'b0, res.locates_left, res.locates_taken, res.final_side,
                         res.reject_reason, res.accepted};

  // checks
  `ASSERT_NEVER(a_ring_overfull, clk_i, rst_ni, status.ring_count > org_pkg::CNT_W'(org_pkg::RING_DEPTH))
  `ASSERT_PROP(a_result_from_work, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(status.busy))
  `ASSERT_PROP(a_queue_drains, clk_i, rst_ni, (q_valid && !status.busy) |=> status.busy)
endmodule

// ===== tb/sv/tb_order_risk_gate.sv =====
// testbench for the order risk gate: random and directed requests checked against a local model
`timescale 1ns / 1ps
module tb_order_risk_gate;

  // risk model and queue of expected results
  class risk_scoreboard;
    logic signed [7:0] rate_lim;
    logic [31:0] size_lim, price_lim;
    logic [62:0] value_lim, pos_value_lim;
    logic [46:0] pos_lim;
    logic [62:0] stamp_ring [org_pkg::RING_DEPTH];
    int ring_first, ring_fill;
    longint balance, allowance;
    bit locates_set;
    org_pkg::org_result_t expected_results [$];
    int errors;

    function new();
      rate_lim = -8'sd1;
      size_lim = 0; price_lim = 0; value_lim = 0; pos_lim = 0; pos_value_lim = 0;
      ring_first = 0; ring_fill = 0; balance = 0; allowance = 0;
      locates_set = 0; errors = 0;
    endfunction

    function void set_limit(org_pkg::org_reg_e idx, logic [63:0] v);
      case (idx)
        org_pkg::REG_RATE_LIMIT: rate_lim = v[7:0];
        org_pkg::REG_SIZE_LIMIT: size_lim = v[31:0];
        org_pkg::REG_PRICE_LIMIT: price_lim = v[31:0];
        org_pkg::REG_VALUE_LIMIT: value_lim = v[62:0];
        org_pkg::REG_POS_LIMIT: pos_lim = v[46:0];
        default: pos_value_lim = v[62:0];
      endcase
    endfunction

    function org_pkg::org_result_t predict_outcome(org_pkg::org_item_t it);
      org_pkg::org_result_t r;
      longint nl, diff, post, apos, need, avail;
      logic [127:0] prod;
      logic [63:0] pval;
      bit rate_on;
      r.accepted = 0;
      r.reject_reason = org_pkg::RSN_OK;
      r.final_side = it.order_side;
      r.locates_taken = 0;
      // live locate allowance change
      if (it.op == org_pkg::OP_LOCATE_UPDATE) begin
        r.final_side = org_pkg::SIDE_BUY;
        nl = longint'(it.locate_target);
        diff = nl - allowance;
        if (!(diff == 0 || (it.grow_only && diff <= 0))) begin
          allowance = nl;
          balance = balance + diff;
          if (balance > 64'sd140737488355327) balance = 64'sd140737488355327;
          if (balance < -64'sd140737488355328) balance = -64'sd140737488355328;
          locates_set = 1;
          r.accepted = 1;
        end
        r.locates_left = balance[47:0];
        return r;
      end
      r.locates_left = balance[47:0];
      // sliding window expiry and rate check
      rate_on = (rate_lim >= 0);
      if (rate_on) begin
        while (ring_fill > 0 &&
               ({1'b0, stamp_ring[ring_first]} + org_pkg::WINDOW_NS) <
               {1'b0, it.order_time_ns}) begin
          ring_first = (ring_first + 1) % org_pkg::RING_DEPTH;
          ring_fill--;
        end
        if (ring_fill + 1 > int'(rate_lim) || ring_fill >= org_pkg::RING_DEPTH) begin
          r.reject_reason = org_pkg::RSN_RATE;
          return r;
        end
      end
      if (it.order_size > size_lim) begin
        r.reject_reason = org_pkg::RSN_SIZE;
        return r;
      end
      if (it.order_price > price_lim) begin
        r.reject_reason = org_pkg::RSN_PRICE;
        return r;
      end
      if (64'(it.order_size) * 64'(it.order_price) > {1'b0, value_lim}) begin
        r.reject_reason = org_pkg::RSN_VALUE;
        return r;
      end
      // post-trade position and its value, saturating
      post = longint'(it.held_quantity) + longint'(it.away_quantity);
      if (it.order_side == org_pkg::SIDE_BUY) post += longint'(it.order_size);
      else post -= longint'(it.order_size);
      apos = (post < 0) ? -post : post;
      if (apos > longint'(pos_lim)) begin
        r.reject_reason = org_pkg::RSN_POSITION;
        return r;
      end
      prod = 128'(apos) * 128'(it.order_price);
      pval = (prod[127:64] != 0) ? '1 : prod[63:0];
      if (pval > {1'b0, pos_value_lim}) begin
        r.reject_reason = org_pkg::RSN_POS_VALUE;
        return r;
      end
      // sell/short correction and locate draw
      need = 0;
      if (it.order_side != org_pkg::SIDE_BUY) begin
        post -= longint'(it.open_short_qty);
        if (post < 0) begin
          r.final_side = org_pkg::SIDE_SHORT;
          need = -post;
        end else begin
          r.final_side = org_pkg::SIDE_SELL;
        end
        if (!locates_set) begin
          r.reject_reason = org_pkg::RSN_UNSET;
          return r;
        end
        avail = (balance > 0) ? balance : 0;
        if (need > avail) begin
          r.reject_reason = org_pkg::RSN_LOCATES;
          return r;
        end
        balance -= need;
      end
      if (rate_on) begin
        stamp_ring[(ring_first + ring_fill) % org_pkg::RING_DEPTH] = it.order_time_ns;
        ring_fill++;
      end
      r.accepted = 1;
      r.locates_taken = need[47:0];
      r.locates_left = balance[47:0];
      return r;
    endfunction

    function void note_request(org_pkg::org_item_t it);
      expected_results.push_back(predict_outcome(it));
    endfunction

    function void check_result(logic [org_pkg::OUT_TDATA_W-1:0] d);
      org_pkg::org_result_t e;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: %h", d);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (d[0] !== e.accepted) begin
        $error("accepted: expected %0d actual %0d", e.accepted, d[0]);
        errors++;
      end
      if (d[4:1] !== e.reject_reason) begin
        $error("reject_reason: expected %0d actual %0d", e.reject_reason, d[4:1]);
        errors++;
      end
      if (d[6:5] !== e.final_side) begin
        $error("final_side: expected %0d actual %0d", e.final_side, d[6:5]);
        errors++;
      end
      if (d[54:7] !== e.locates_taken) begin
        $error("locates_taken: expected %0d actual %0d", e.locates_taken, d[54:7]);
        errors++;
      end
      if (d[102:55] !== e.locates_left) begin
        $error("locates_left: expected %0d actual %0d", e.locates_left, $signed(d[102:55]));
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic [org_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser, s_axis_tvalid, s_axis_tready;
  logic [org_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic psel, penable, pwrite, pready;
  logic [org_pkg::APB_AW-1:0] paddr;
  logic [org_pkg::APB_DW-1:0] pwdata, prdata;

  risk_scoreboard sb;
  org_pkg::org_item_t cur_item;
  logic [62:0] clock_ns;
  int unsigned step_max;
  bit tx_quiet, rx_quiet;

  order_risk_gate uut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // request and result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(cur_item);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // result receiver with random stalls
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic org_pkg::org_item_t make_item(org_pkg::org_op_e op, logic [62:0] t,
      logic [31:0] sz, logic [31:0] px, org_pkg::org_side_e sd, logic [47:0] held,
      logic [47:0] remote, logic [46:0] sopen, logic [47:0] nloc, logic only);
    org_pkg::org_item_t it;
    it.op = op; it.order_time_ns = t; it.order_size = sz; it.order_price = px;
    it.order_side = sd; it.held_quantity = held; it.away_quantity = remote;
    it.open_short_qty = sopen; it.locate_target = nloc; it.grow_only = only;
    return it;
  endfunction

  // mostly plausible orders, with some full-range noise
  function automatic org_pkg::org_item_t random_item();
    org_pkg::org_item_t it;
    bit wild;
    wild = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 99) == 0) clock_ns = 63'({$urandom(), $urandom()});
    else if ($urandom_range(0, 29) == 0) clock_ns += 63'd2000000000;
    else clock_ns += 63'($urandom_range(0, step_max));
    it = make_item(org_pkg::org_op_e'(($urandom_range(0, 6) == 0) ?
                                      org_pkg::OP_LOCATE_UPDATE : org_pkg::OP_VALIDATE),
                   clock_ns,
                   wild ? $urandom() : $urandom_range(0, 2000),
                   wild ? $urandom() : $urandom_range(0, 3000),
                   org_pkg::org_side_e'($urandom_range(0, 3)),
                   wild ? rand48() : 48'($urandom_range(0, 4000)),
                   wild ? rand48() : 48'($urandom_range(0, 2000)),
                   wild ? 47'(rand48()) : 47'($urandom_range(0, 1500)),
                   wild ? rand48() : 48'($urandom_range(0, 30000)),
                   1'($urandom_range(0, 1)));
    return it;
  endfunction

  task automatic send_request(org_pkg::org_item_t it);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_item = it;
    s_axis_tdata <= {7'b0, it.grow_only, it.locate_target, it.open_short_qty,
                     it.away_quantity, it.held_quantity, it.order_side, it.order_price,
                     it.order_size, it.order_time_ns};
    s_axis_tuser <= it.op;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(org_pkg::org_reg_e idx, logic [63:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= org_pkg::APB_AW'(idx) << 3; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_limit(idx, v);
    @(negedge clk_i);
  endtask

  task automatic set_limits(logic [7:0] rl, logic [31:0] sl, logic [31:0] pl,
                            logic [62:0] vl, logic [46:0] ql, logic [62:0] pvl);
    write_reg(org_pkg::REG_RATE_LIMIT, 64'(signed'(rl)));
    write_reg(org_pkg::REG_SIZE_LIMIT, 64'(sl));
    write_reg(org_pkg::REG_PRICE_LIMIT, 64'(pl));
    write_reg(org_pkg::REG_VALUE_LIMIT, 64'(vl));
    write_reg(org_pkg::REG_POS_LIMIT, 64'(ql));
    write_reg(org_pkg::REG_POS_VALUE_LIMIT, 64'(pvl));
  endtask

  // hard stop
  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int n, waited;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tuser = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    clock_ns = 0; step_max = 20000000; tx_quiet = 0; rx_quiet = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset limits: a zero size sell without locates, and a buy over the zero size limit
    send_request(make_item(org_pkg::OP_VALIDATE, 0, 0, 0, org_pkg::SIDE_SELL, 0, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 5, 1, 0, org_pkg::SIDE_BUY, 0, 0, 0, 0, 0));
    wait_drained();

    // directed cases with the rate check off and every other limit at its top
    set_limits(8'hff, '1, '1, '1, '1, '1);
    send_request(make_item(org_pkg::OP_VALIDATE, 10, 10, 10, org_pkg::SIDE_SHORT,
                           0, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_LOCATE_UPDATE, 0, 0, 0, org_pkg::SIDE_BUY,
                           0, 0, 0, 0, 1));
    send_request(make_item(org_pkg::OP_LOCATE_UPDATE, 0, 0, 0, org_pkg::SIDE_BUY,
                           0, 0, 0, -48'sd5, 1));
    send_request(make_item(org_pkg::OP_LOCATE_UPDATE, 0, 0, 0, org_pkg::SIDE_BUY,
                           0, 0, 0, -48'sd5, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 20, 1, 1, org_pkg::SIDE_SHORT,
                           0, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 20, 0, 1, org_pkg::SIDE_SELL,
                           0, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_LOCATE_UPDATE, 0, 0, 0, org_pkg::SIDE_BUY,
                           0, 0, 0, 48'd1000, 1));
    send_request(make_item(org_pkg::OP_VALIDATE, 30, 10, 5, org_pkg::SIDE_SELL,
                           100, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 31, 50, 5, org_pkg::SIDE_SELL,
                           0, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 32, 7, 5, org_pkg::SIDE_SHORT_EXEMPT,
                           1000, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 33, 5000, 5, org_pkg::SIDE_SHORT,
                           0, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 34, '1, '1, org_pkg::SIDE_BUY,
                           0, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 35, 0, 3, org_pkg::SIDE_BUY,
                           48'h7fffffffffff, 48'h7fffffffffff, 0, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 36, 0, '1, org_pkg::SIDE_BUY,
                           48'h10000000000, 0, 0, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 37, 1, 1, org_pkg::SIDE_SELL,
                           48'h800000000000, 48'h800000000000, '1, 0, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, 38, 3, 1, org_pkg::SIDE_SELL,
                           0, 0, '1, 0, 0));
    send_request(make_item(org_pkg::OP_LOCATE_UPDATE, '1, 0, 0, org_pkg::SIDE_BUY,
                           0, 0, 0, 48'h7fffffffffff, 0));
    send_request(make_item(org_pkg::OP_LOCATE_UPDATE, '1, 0, 0, org_pkg::SIDE_BUY,
                           0, 0, 0, 48'h800000000000, 0));
    send_request(make_item(org_pkg::OP_LOCATE_UPDATE, '1, 0, 0, org_pkg::SIDE_BUY,
                           0, 0, 0, 48'h7fffffffffff, 0));
    send_request(make_item(org_pkg::OP_VALIDATE, '1, 2, 2, org_pkg::SIDE_SHORT,
                           0, 0, 0, 0, 0));
    wait_drained();
    clock_ns = 0;

    // random phases over a spread of limit settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin set_limits(8'd8, 10000, 10000, 63'd1 << 40, '1, '1); step_max = 20000000; end
        1: begin set_limits(8'hff, '1, '1, '1, '1, '1); step_max = 20000000; end
        2: begin set_limits(8'd64, '1, '1, '1, '1, '1); step_max = 3000000; end
        3: begin set_limits(8'd0, '1, '1, '1, '1, '1); step_max = 5000000; end
        4: begin set_limits(8'd1, 1500, 2500, 2000000, 5000, 10000000); step_max = 400000000; end
        default: begin
          set_limits(8'($urandom_range(1, 20)), $urandom_range(500, 3000),
                     $urandom_range(500, 3000), 63'($urandom_range(100000, 9000000)),
                     47'($urandom_range(1000, 8000)), 63'($urandom_range(100000, 30000000)));
          step_max = 30000000;
        end
      endcase
      for (n = 0; n < 140; n++) begin
        if (n % 35 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        // hold off until the block has caught up
        if (n == 70) begin
          s_axis_tvalid <= 1'b0;
          while (sb.expected_results.size() != 0) @(negedge clk_i);
          @(negedge clk_i);
        end
        send_request(random_item());
      end
      wait_drained();
    end

    // drain and finish
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (sb.expected_results.size() != 0 && waited < 200000) begin
      @(negedge clk_i);
      waited++;
    end
    if (sb.expected_results.size() != 0) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      repeat (40) @(negedge clk_i);
      if (sb.errors == 0 && sb.expected_results.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        if (sb.expected_results.size() != 0)
          $error("%0d expected results never arrived", sb.expected_results.size());
        $display("Simulation FAILED");
      end
      $finish;
    end
  end
endmodule
